FILE: rtl/pvms_pkg.sv
// Package for the pump and valve sequencer: widths, step codes, register
// indexes, and the state, drive-level and result types.
// No dependencies.
`timescale 1ns / 1ps

package pvms_pkg;

  // Counter and register widths
  localparam int COUNT_WIDTH = 16;
  localparam int CFG_WIDTH   = 16;
  localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
  localparam int STEP_WIDTH  = 3;
  localparam int IDX_WIDTH   = 2;

  // Configuration register indexes
  localparam logic [IDX_WIDTH-1:0] REG_SHORT_DELAY = 2'd0;
  localparam logic [IDX_WIDTH-1:0] REG_IDLE_WAIT   = 2'd1;
  localparam logic [IDX_WIDTH-1:0] REG_FLUSH       = 2'd2;
  localparam logic [IDX_WIDTH-1:0] REG_MAX_RUN     = 2'd3;

  // Register reset values
  localparam logic [CFG_WIDTH-1:0] SHORT_DELAY_RST = 16'd10;
  localparam logic [CFG_WIDTH-1:0] IDLE_WAIT_RST   = 16'd6000;
  localparam logic [CFG_WIDTH-1:0] FLUSH_RST       = 16'd1200;
  localparam logic [CFG_WIDTH-1:0] MAX_RUN_RST     = 16'd24000;

  // Sequence steps
  typedef enum logic [STEP_WIDTH-1:0] {
    STEP_OPEN_INLET = 3'd0,
    STEP_PUMP_DELAY = 3'd1,
    STEP_DISPENSE   = 3'd2,
    STEP_CLOSE      = 3'd3,
    STEP_STOP_DELAY = 3'd4,
    STEP_IDLE_WAIT  = 3'd5,
    STEP_FLUSH      = 3'd6,
    STEP_PARKED     = 3'd7
  } step_t;

  // Held output levels
  typedef struct packed {
    logic inlet;
    logic pump;
    logic ret;
    logic led;
    logic prun;
    logic disp;
  } levels_t;

  // Sequencer state
  typedef struct packed {
    step_t                  step;
    logic [COUNT_WIDTH-1:0] phase_cnt;
    logic [COUNT_WIDTH-1:0] run_cnt;
    logic                   making;
    levels_t                lv;
  } seq_state_t;

  // Configuration set
  typedef struct packed {
    logic [CFG_WIDTH-1:0] short_delay;
    logic [CFG_WIDTH-1:0] idle_wait;
    logic [CFG_WIDTH-1:0] flush;
    logic [CFG_WIDTH-1:0] max_run;
  } cfg_t;

  // One result beat
  typedef struct packed {
    logic                  inlet_valve;
    logic                  pump_drive;
    logic                  return_valve;
    logic                  making_led;
    logic                  pump_running;
    logic                  dispensing;
    logic                  making_active;
    logic                  fault_raise;
    logic [STEP_WIDTH-1:0] sequence_step;
  } res_t;

endpackage

FILE: rtl/pvms_step.sv
// Per-tick next-state and result logic of the pump and valve sequencer.
// Depends on pvms_pkg.
`timescale 1ns / 1ps

module pvms_step (
  input  pvms_pkg::seq_state_t cur,
  input  pvms_pkg::cfg_t       cfg,
  input  logic                 pressure_switch,
  input  logic                 fault_active,
  input  logic                 factory_mode,
  input  logic                 system_running,
  input  logic                 first_power_on,
  output pvms_pkg::seq_state_t nxt,
  output pvms_pkg::res_t       res
);
  import pvms_pkg::*;

  logic                   frozen;
  logic                   raise;
  logic [COUNT_WIDTH-1:0] phase_inc;
  logic [COUNT_WIDTH-1:0] run_before;
  step_t                  eff_step;

  assign frozen    = fault_active | factory_mode | ~system_running | first_power_on;
  assign phase_inc = cur.phase_cnt + COUNT_WIDTH'(1);

  // Advance the sequence by one tick
  always_comb begin
    nxt        = cur;
    raise      = 1'b0;
    run_before = cur.run_cnt;
    eff_step   = cur.step;
    if (!frozen) begin
      // Start a run on demand
      if (pressure_switch && !cur.making) begin
        eff_step   = STEP_OPEN_INLET;
        nxt.making = 1'b1;
        nxt.lv.ret = 1'b0;
      end
      nxt.step = eff_step;
      case (eff_step)
        STEP_OPEN_INLET: begin
          nxt.lv.inlet = 1'b1;
          nxt.lv.led   = 1'b1;
          nxt.lv.prun  = 1'b1;
          nxt.step     = STEP_PUMP_DELAY;
        end
        STEP_PUMP_DELAY: begin
          nxt.phase_cnt = phase_inc;
          if (CMP_WIDTH'(phase_inc) > CMP_WIDTH'(cfg.short_delay)) begin
            nxt.phase_cnt = '0;
            nxt.lv.pump   = 1'b1;
            nxt.lv.disp   = 1'b1;
            nxt.step      = STEP_DISPENSE;
          end
        end
        STEP_DISPENSE: begin
          if (!pressure_switch) begin
            run_before = '0;
            nxt.step   = STEP_CLOSE;
            nxt.lv.led = 1'b0;
          end
          nxt.run_cnt = run_before + COUNT_WIDTH'(1);
          // Overrun: drop every valve and the pump
          if (CMP_WIDTH'(run_before) > CMP_WIDTH'(cfg.max_run)) begin
            nxt.lv.disp  = 1'b0;
            nxt.lv.inlet = 1'b0;
            nxt.lv.pump  = 1'b0;
            nxt.lv.ret   = 1'b0;
            raise        = 1'b1;
          end
        end
        STEP_CLOSE: begin
          nxt.lv.inlet  = 1'b0;
          nxt.phase_cnt = '0;
          nxt.step      = STEP_STOP_DELAY;
          nxt.making    = 1'b0;
        end
        STEP_STOP_DELAY: begin
          nxt.phase_cnt = phase_inc;
          if (CMP_WIDTH'(phase_inc) > CMP_WIDTH'(cfg.short_delay)) begin
            nxt.phase_cnt = '0;
            nxt.lv.pump   = 1'b0;
            nxt.lv.prun   = 1'b0;
            nxt.lv.disp   = 1'b0;
            nxt.step      = STEP_IDLE_WAIT;
          end
        end
        STEP_IDLE_WAIT: begin
          nxt.phase_cnt = phase_inc;
          if (CMP_WIDTH'(phase_inc) > CMP_WIDTH'(cfg.idle_wait)) begin
            nxt.phase_cnt = '0;
            nxt.step      = STEP_FLUSH;
          end
        end
        STEP_FLUSH: begin
          nxt.phase_cnt = phase_inc;
          if (CMP_WIDTH'(phase_inc) > CMP_WIDTH'(cfg.flush)) begin
            nxt.phase_cnt = '0;
            nxt.step      = STEP_PARKED;
            nxt.lv.ret    = 1'b0;
            nxt.lv.pump   = 1'b0;
          end else begin
            nxt.lv.ret  = 1'b1;
            nxt.lv.pump = 1'b1;
          end
          if (pressure_switch) begin
            nxt.lv.ret = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Present the levels after this tick
  always_comb begin
    res.inlet_valve   = nxt.lv.inlet;
    res.pump_drive    = nxt.lv.pump;
    res.return_valve  = nxt.lv.ret;
    res.making_led    = nxt.lv.led;
    res.pump_running  = nxt.lv.prun;
    res.dispensing    = nxt.lv.disp;
    res.making_active = nxt.making;
    res.fault_raise   = raise;
    res.sequence_step = nxt.step;
  end

endmodule

FILE: rtl/pvms_obuf.sv
// Two-entry result buffer (output register plus skid entry) for the sequencer.
// Depends on pvms_pkg.
`timescale 1ns / 1ps

module pvms_obuf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pvms_pkg::res_t push_data,
  input  logic           out_stall,
  output logic           out_valid,
  output pvms_pkg::res_t out_data,
  output logic           full
);
  import pvms_pkg::*;

  logic main_valid;
  logic main_valid_next;
  logic skid_valid;
  logic skid_valid_next;
  res_t main_data;
  res_t main_data_next;
  res_t skid_data;
  res_t skid_data_next;
  logic pop;

  assign pop       = main_valid & ~out_stall;
  assign out_valid = main_valid;
  assign out_data  = main_data;
  assign full      = skid_valid;

  // Move beats between the skid entry and the output register
  always_comb begin
    main_valid_next = main_valid;
    skid_valid_next = skid_valid;
    main_data_next  = main_data;
    skid_data_next  = skid_data;
    if (pop) begin
      if (skid_valid) begin
        main_data_next  = skid_data;
        skid_valid_next = 1'b0;
      end else if (push) begin
        main_data_next = push_data;
      end else begin
        main_valid_next = 1'b0;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_data_next  = push_data;
        main_valid_next = 1'b1;
      end else begin
        skid_data_next  = push_data;
        skid_valid_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      main_valid <= main_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    main_data <= main_data_next;
    skid_data <= skid_data_next;
  end

endmodule

FILE: rtl/pump_valve_make_sequencer.sv
// Top level of the pump and valve sequencer: configuration registers, state
// registers and the result buffer. Depends on pvms_pkg, pvms_step, pvms_obuf.
`timescale 1ns / 1ps

// One tick beat is taken per clock cycle while in_stall is low, and its result
// beat is registered on accept. The sequence state updates in the same
// cycle as the accept through a single pass of compare and increment logic, so
// back-to-back ticks never wait on each other. A two-entry result buffer (output
// register and skid entry) lets a tick be accepted while one result is stalled;
// in_stall rises only when both entries hold unread results. After reset the
// sequence sits in the idle wait step (5) with every output level off.
module pump_valve_make_sequencer (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_write,
  input  logic [pvms_pkg::IDX_WIDTH-1:0]     cfg_index,
  input  logic [pvms_pkg::CFG_WIDTH-1:0]     cfg_data,
  // tick input
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               pressure_switch,
  input  logic                               fault_active,
  input  logic                               factory_mode,
  input  logic                               system_running,
  input  logic                               first_power_on,
  // result output
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               inlet_valve,
  output logic                               pump_drive,
  output logic                               return_valve,
  output logic                               making_led,
  output logic                               pump_running,
  output logic                               dispensing,
  output logic                               making_active,
  output logic                               fault_raise,
  output logic [pvms_pkg::STEP_WIDTH-1:0]    sequence_step
);
  import pvms_pkg::*;

  cfg_t       cfg;
  seq_state_t state;
  seq_state_t state_next;
  res_t       res;
  res_t       out_data;
  logic       accept;
  logic       buf_full;

  assign in_stall = buf_full;
  assign accept   = in_valid & ~buf_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_delay <= SHORT_DELAY_RST;
      cfg.idle_wait   <= IDLE_WAIT_RST;
      cfg.flush       <= FLUSH_RST;
      cfg.max_run     <= MAX_RUN_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SHORT_DELAY: cfg.short_delay <= cfg_data;
        REG_IDLE_WAIT:   cfg.idle_wait   <= cfg_data;
        REG_FLUSH:       cfg.flush       <= cfg_data;
        REG_MAX_RUN:     cfg.max_run     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pvms_step u_step (
    .cur             (state),
    .cfg             (cfg),
    .pressure_switch (pressure_switch),
    .fault_active    (fault_active),
    .factory_mode    (factory_mode),
    .system_running  (system_running),
    .first_power_on  (first_power_on),
    .nxt             (state_next),
    .res             (res)
  );

  // Advance the sequence on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      state.step      <= STEP_IDLE_WAIT;
      state.phase_cnt <= '0;
      state.run_cnt   <= '0;
      state.making    <= 1'b0;
      state.lv        <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  pvms_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .full      (buf_full)
  );

  assign inlet_valve   = out_data.inlet_valve;
  assign pump_drive    = out_data.pump_drive;
  assign return_valve  = out_data.return_valve;
  assign making_led    = out_data.making_led;
  assign pump_running  = out_data.pump_running;
  assign dispensing    = out_data.dispensing;
  assign making_active = out_data.making_active;
  assign fault_raise   = out_data.fault_raise;
  assign sequence_step = out_data.sequence_step;

endmodule

FILE: rtl/pvms_checker.sv
// Port-level checks for the pump and valve sequencer, bound to the top level.
// Depends on pvms_pkg and pump_valve_make_sequencer.
`timescale 1ns / 1ps

module pvms_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic                               inlet_valve,
  input logic                               pump_drive,
  input logic                               return_valve,
  input logic                               dispensing,
  input logic                               making_active,
  input logic                               fault_raise,
  input logic [pvms_pkg::STEP_WIDTH-1:0]    sequence_step
);
  import pvms_pkg::*;

  // Input side only backs up when a result is waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("in_stall high with no result pending");

  // A stalled result beat holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sequence_step)
      && $stable(fault_raise) && $stable(inlet_valve) && $stable(pump_drive))
    else $error("stalled result beat changed");

  // An overrun beat shows both valves, the pump and dispensing off
  a_fault_all_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && fault_raise |-> !inlet_valve && !pump_drive && !return_valve
      && !dispensing)
    else $error("overrun fault with a valve or the pump still on");

  // Steps inside a run report the run active
  a_run_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && (sequence_step == STEP_PUMP_DELAY || sequence_step == STEP_DISPENSE
      || sequence_step == STEP_CLOSE) |-> making_active)
    else $error("run step shown without making_active");

  // The open-inlet step is always passed through within a tick
  a_no_start_step: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sequence_step != STEP_OPEN_INLET)
    else $error("result shows the transient open-inlet step");

endmodule

bind pump_valve_make_sequencer pvms_checker u_pvms_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .inlet_valve   (inlet_valve),
  .pump_drive    (pump_drive),
  .return_valve  (return_valve),
  .dispensing    (dispensing),
  .making_active (making_active),
  .fault_raise   (fault_raise),
  .sequence_step (sequence_step)
);

FILE: tb/tb.sv
// Self-checking bench for pump_valve_make_sequencer: random bursts of tick beats
// with a stalling receiver, checked against an in-bench model of the sequencer.
// Depends on pvms_pkg and the RTL of the sequencer.
`timescale 1ns / 1ps

module tb;
  import pvms_pkg::*;

  // One tick beat as driven on the input side
  typedef struct packed {
    logic sw;
    logic fault;
    logic factory;
    logic running;
    logic first_on;
  } tick_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_write = 1'b0;
  logic [IDX_WIDTH-1:0]  cfg_index = '0;
  logic [CFG_WIDTH-1:0]  cfg_data = '0;

  logic in_valid = 1'b0;
  logic in_stall;
  logic pressure_switch = 1'b0;
  logic fault_active = 1'b0;
  logic factory_mode = 1'b0;
  logic system_running = 1'b0;
  logic first_power_on = 1'b0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  inlet_valve;
  logic                  pump_drive;
  logic                  return_valve;
  logic                  making_led;
  logic                  pump_running;
  logic                  dispensing;
  logic                  making_active;
  logic                  fault_raise;
  logic [STEP_WIDTH-1:0] sequence_step;

  pump_valve_make_sequencer uut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .pressure_switch (pressure_switch),
    .fault_active    (fault_active),
    .factory_mode    (factory_mode),
    .system_running  (system_running),
    .first_power_on  (first_power_on),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .inlet_valve     (inlet_valve),
    .pump_drive      (pump_drive),
    .return_valve    (return_valve),
    .making_led      (making_led),
    .pump_running    (pump_running),
    .dispensing      (dispensing),
    .making_active   (making_active),
    .fault_raise     (fault_raise),
    .sequence_step   (sequence_step)
  );

  always #5 clk = ~clk;

  // Model state of the sequencer, starting from its reset values
  cfg_t                   settings = '{SHORT_DELAY_RST, IDLE_WAIT_RST, FLUSH_RST, MAX_RUN_RST};
  step_t                  step = STEP_IDLE_WAIT;
  logic [COUNT_WIDTH-1:0] phase_cnt = '0;
  logic [COUNT_WIDTH-1:0] run_cnt = '0;
  logic                   making = 1'b0;
  levels_t                lv = '0;

  tick_t pending_ticks[$];
  res_t  expected_outputs[$];
  int    mismatch_count = 0;

  // Advance the model by one tick and return the output beat it produces
  function automatic res_t advance_sequencer(input tick_t t);
    res_t                   r;
    logic [COUNT_WIDTH-1:0] prior;
    logic                   raise;
    raise = 1'b0;
    if (!(t.fault || t.factory || !t.running || t.first_on)) begin
      // Demand with no run in progress restarts at step 0; phase count carries over
      if (t.sw && !making) begin
        step = STEP_OPEN_INLET;
        making = 1'b1;
        lv.ret = 1'b0;
      end
      case (step)
        STEP_OPEN_INLET: begin
          lv.inlet = 1'b1;
          lv.led = 1'b1;
          lv.prun = 1'b1;
          step = STEP_PUMP_DELAY;
        end
        STEP_PUMP_DELAY: begin
          phase_cnt = phase_cnt + 1'b1;
          if (phase_cnt > settings.short_delay) begin
            phase_cnt = '0;
            lv.pump = 1'b1;
            lv.disp = 1'b1;
            step = STEP_DISPENSE;
          end
        end
        STEP_DISPENSE: begin
          if (!t.sw) begin
            run_cnt = '0;
            step = STEP_CLOSE;
            lv.led = 1'b0;
          end
          // Overrun test uses the count before the increment
          prior = run_cnt;
          run_cnt = run_cnt + 1'b1;
          if (prior > settings.max_run) begin
            lv.disp = 1'b0;
            lv.inlet = 1'b0;
            lv.pump = 1'b0;
            lv.ret = 1'b0;
            raise = 1'b1;
          end
        end
        STEP_CLOSE: begin
          lv.inlet = 1'b0;
          phase_cnt = '0;
          step = STEP_STOP_DELAY;
          making = 1'b0;
        end
        STEP_STOP_DELAY: begin
          phase_cnt = phase_cnt + 1'b1;
          if (phase_cnt > settings.short_delay) begin
            phase_cnt = '0;
            lv.pump = 1'b0;
            lv.prun = 1'b0;
            lv.disp = 1'b0;
            step = STEP_IDLE_WAIT;
          end
        end
        STEP_IDLE_WAIT: begin
          phase_cnt = phase_cnt + 1'b1;
          if (phase_cnt > settings.idle_wait) begin
            phase_cnt = '0;
            step = STEP_FLUSH;
          end
        end
        STEP_FLUSH: begin
          phase_cnt = phase_cnt + 1'b1;
          if (phase_cnt > settings.flush) begin
            phase_cnt = '0;
            step = STEP_PARKED;
            lv.ret = 1'b0;
            lv.pump = 1'b0;
          end else begin
            lv.ret = 1'b1;
            lv.pump = 1'b1;
          end
          if (t.sw) lv.ret = 1'b0;
        end
        default: begin
          // parked: hold until a run starts
        end
      endcase
    end
    r.inlet_valve   = lv.inlet;
    r.pump_drive    = lv.pump;
    r.return_valve  = lv.ret;
    r.making_led    = lv.led;
    r.pump_running  = lv.prun;
    r.dispensing    = lv.disp;
    r.making_active = making;
    r.fault_raise   = raise;
    r.sequence_step = step;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [2:0] got,
                               input logic [2:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // Input driver: bursts of beats with random gaps; hold a beat until accepted
  tick_t next_tick;
  int    burst_left = 0;
  int    gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_outputs.push_back(advance_sequencer({pressure_switch, fault_active,
                                                      factory_mode, system_running,
                                                      first_power_on}));
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          next_tick = pending_ticks.pop_front();
          pressure_switch <= next_tick.sw;
          fault_active <= next_tick.fault;
          factory_mode <= next_tick.factory;
          system_running <= next_tick.running;
          first_power_on <= next_tick.first_on;
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 32);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output stall: rotate a pattern that is replaced now and then
  logic [15:0] stall_pattern = '0;
  int          pattern_age = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      pattern_age <= 0;
    end else if (pattern_age == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pattern <= 16'h0000;
        1:       stall_pattern <= 16'($urandom()) & 16'hFFFE;
        2:       stall_pattern <= 16'($urandom() & $urandom()) & 16'hFFFE;
        default: stall_pattern <= 16'h7FFE;
      endcase
      pattern_age <= $urandom_range(16, 96);
      out_stall <= 1'b0;
    end else begin
      stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
      pattern_age <= pattern_age - 1;
      out_stall <= stall_pattern[0];
    end
  end

  // Output monitor: compare each accepted beat with the oldest expectation
  res_t seen_result;
  res_t want_result;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_result = {inlet_valve, pump_drive, return_valve, making_led, pump_running,
                     dispensing, making_active, fault_raise, sequence_step};
      if (expected_outputs.size() == 0) begin
        report_mismatch($sformatf("output beat %h with nothing expected", seen_result));
      end else begin
        want_result = expected_outputs.pop_front();
        compare_field("inlet_valve", seen_result.inlet_valve, want_result.inlet_valve);
        compare_field("pump_drive", seen_result.pump_drive, want_result.pump_drive);
        compare_field("return_valve", seen_result.return_valve, want_result.return_valve);
        compare_field("making_led", seen_result.making_led, want_result.making_led);
        compare_field("pump_running", seen_result.pump_running, want_result.pump_running);
        compare_field("dispensing", seen_result.dispensing, want_result.dispensing);
        compare_field("making_active", seen_result.making_active,
                      want_result.making_active);
        compare_field("fault_raise", seen_result.fault_raise, want_result.fault_raise);
        compare_field("sequence_step", seen_result.sequence_step,
                      want_result.sequence_step);
      end
    end
  end

  task automatic queue_tick(input logic sw, input logic fault, input logic factory,
                            input logic running, input logic first_on);
    pending_ticks.push_back('{sw, fault, factory, running, first_on});
  endtask

  // Demand on and off in runs of random length, with occasional gating and glitches
  task automatic queue_random_ticks(input int count);
    logic level;
    int   run_len;
    logic sw;
    level = 1'($urandom_range(0, 1));
    run_len = 0;
    repeat (count) begin
      if (run_len == 0) begin
        level = ~level;
        run_len = level ? $urandom_range(1, 60) : $urandom_range(1, 70);
      end
      run_len--;
      sw = ($urandom_range(0, 24) == 0) ? ~level : level;
      if ($urandom_range(0, 9) == 0)
        queue_tick(sw, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else
        queue_tick(sw, 1'b0, 1'b0, 1'b1, 1'b0);
    end
  endtask

  // Drain: no beat pending, none on the port, none in flight
  task automatic wait_for_drain();
    while (pending_ticks.size() != 0 || in_valid || expected_outputs.size() != 0)
      @(posedge clk);
  endtask

  // Write all four registers back to back; only called while drained
  task automatic load_settings(input cfg_t c);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_SHORT_DELAY;
    cfg_data <= c.short_delay;
    @(posedge clk);
    cfg_index <= REG_IDLE_WAIT;
    cfg_data <= c.idle_wait;
    @(posedge clk);
    cfg_index <= REG_FLUSH;
    cfg_data <= c.flush;
    @(posedge clk);
    cfg_index <= REG_MAX_RUN;
    cfg_data <= c.max_run;
    @(posedge clk);
    cfg_write <= 1'b0;
    settings = c;
  endtask

  // Stimulus sequence
  initial begin
    cfg_t mixed;
    int   k;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, each freeze gate, run start with carried phase count,
    // pump start, freeze in dispense, release, restart during stop delay
    queue_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    queue_tick(1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
    queue_tick(1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
    queue_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_tick(1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
    repeat (13) queue_tick(1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
    queue_tick(1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
    repeat (3) queue_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    queue_tick(1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
    queue_tick(1'b0, 1'b1, 1'b1, 1'b0, 1'b1);
    queue_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    wait_for_drain();

    // Lowest settings
    load_settings('{16'd1, 16'd1, 16'd1, 16'd1});
    queue_random_ticks(250);
    wait_for_drain();

    // Short random settings so every step and the overrun come round often
    for (k = 0; k < 4; k++) begin
      mixed.short_delay = 16'($urandom_range(1, 4));
      mixed.idle_wait = 16'($urandom_range(1, 24));
      mixed.flush = 16'($urandom_range(1, 24));
      mixed.max_run = 16'($urandom_range(1, 70));
      load_settings(mixed);
      queue_random_ticks(200);
      wait_for_drain();
    end

    // High settings, one below the largest 16-bit value
    load_settings('{16'd65534, 16'd65534, 16'd65534, 16'd65534});
    queue_random_ticks(100);
    wait_for_drain();

    // One long run: the overrun repeats each tick, then the switch opens
    load_settings('{16'd1, 16'd1, 16'd1, 16'd120});
    repeat (5) queue_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    repeat (150) queue_tick(1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
    repeat (20) queue_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    wait_for_drain();

    mixed.short_delay = 16'($urandom_range(1, 4));
    mixed.idle_wait = 16'($urandom_range(1, 24));
    mixed.flush = 16'($urandom_range(1, 24));
    mixed.max_run = 16'($urandom_range(1, 70));
    load_settings(mixed);
    queue_random_ticks(100);
    wait_for_drain();

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #100_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/pvms_pkg.sv
rtl/pvms_step.sv
rtl/pvms_obuf.sv
rtl/pump_valve_make_sequencer.sv
rtl/pvms_checker.sv
tb/tb.sv
